FILE: design/rational_arithmetic_unit_macros.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Shared concurrent assertion forms for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, error codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

  localparam int unsigned DEFAULT_WIDTH = 32;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_DIV       = 4'd3,
    OP_EQ        = 4'd4,
    OP_NE        = 4'd5,
    OP_LT        = 4'd6,
    OP_LE        = 4'd7,
    OP_GT        = 4'd8,
    OP_GE        = 4'd9,
    OP_INC       = 4'd10,
    OP_DEC       = 4'd11,
    OP_NORMALIZE = 4'd12,
    OP_INTVALUE  = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_DEN = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FORM,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_CHECK,
    ST_OUT
  } state_e;

endpackage

FILE: design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact fraction arithmetic and comparison with gcd reduction, one request at
// a time on a shared multiplier, gcd stepper and restoring divider.
// ----------------------------------------------------------------------------
// The single WIDTH x WIDTH multiplier first forms the four cross products in
// turn for every request; comparisons and unused codes finish right after.
// Fraction results then run a binary gcd (one shift or subtract a cycle)
// and two restoring divisions by the gcd; intvalue runs one division only.
// The result is held in an output register until taken; no new request is
// taken until then.
`timescale 1ns / 1ps
`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::DEFAULT_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [3:0]              op_i,
  input  logic signed [WIDTH-1:0] a_num_i,
  input  logic signed [WIDTH-1:0] a_den_i,
  input  logic signed [WIDTH-1:0] b_num_i,
  input  logic [WIDTH-2:0]        b_den_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WIDTH-1:0] res_num_o,
  output logic [WIDTH-2:0]        res_den_o,
  output logic                    cmp_true_o,
  output logic [1:0]              error_o
);

  localparam int unsigned DW = 2 * WIDTH;
  localparam int unsigned CW = $clog2(DW);
  localparam logic [DW-1:0] LIM = {{(WIDTH + 1){1'b0}}, {(WIDTH - 1){1'b1}}};
  localparam logic [DW-1:0] LIM_NEG = LIM + DW'(1);

  rau_pkg::state_e state_q, state_d;

  // Request registers
  logic [3:0]              op_q, op_d;
  logic signed [WIDTH-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d;
  logic [WIDTH-2:0]        bd_q, bd_d;

  // Cross products: an*bd, ad*bn, ad*bd, an*bn
  logic signed [DW-1:0] prod_q [4];
  logic signed [DW-1:0] prod_s;
  logic [1:0]           mul_cnt_q, mul_cnt_d;

  // Magnitudes and sign of the formed fraction
  logic [DW-1:0] mn_q, mn_d, md_q, md_d;
  logic          neg_q, neg_d;

  // Binary gcd
  logic [DW-1:0] u_q, u_d, v_q, v_d;
  logic [CW-1:0] k_q, k_d;

  // Restoring divider
  logic [DW-1:0] rem_q, rem_d, quo_q, quo_d, div_q, div_d, qn_q, qn_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Result register
  logic [WIDTH-1:0] res_num_q, res_num_d;
  logic [WIDTH-2:0] res_den_q, res_den_d;
  logic             cmp_q, cmp_d;
  rau_pkg::err_e    err_q, err_d;

  // Combinational helpers
  logic signed [WIDTH-1:0] mul_x, mul_y;
  logic signed [DW-1:0]    an_x, ad_x, n_s, d_s, diff_s;
  logic                    is_frac, is_cmp, is_int;
  logic                    eq_s, lt_s, gt_s, cmp_s;
  logic [DW:0]             rem_sh, rem_nx;
  logic                    ge_s;
  logic [DW-1:0]           quo_nx, qd_s;
  logic                    neg_eff, ovf_s;

  // Shared multiplier: one cross product per cycle
  always_comb begin
    case (mul_cnt_q)
      2'd0:    begin mul_x = an_q; mul_y = $signed({1'b0, bd_q}); end
      2'd1:    begin mul_x = ad_q; mul_y = bn_q; end
      2'd2:    begin mul_x = ad_q; mul_y = $signed({1'b0, bd_q}); end
      default: begin mul_x = an_q; mul_y = bn_q; end
    endcase
    prod_s = DW'(mul_x) * DW'(mul_y);
  end

  // Form numerator and denominator of the raw result
  always_comb begin
    an_x    = DW'(an_q);
    ad_x    = DW'(ad_q);
    is_cmp  = op_q inside {[rau_pkg::OP_EQ:rau_pkg::OP_GE]};
    is_int  = (op_q == rau_pkg::OP_INTVALUE);
    is_frac = 1'b1;
    case (op_q)
      rau_pkg::OP_ADD:       begin n_s = prod_q[0] + prod_q[1]; d_s = prod_q[2]; end
      rau_pkg::OP_SUB:       begin n_s = prod_q[0] - prod_q[1]; d_s = prod_q[2]; end
      rau_pkg::OP_MUL:       begin n_s = prod_q[3]; d_s = prod_q[2]; end
      rau_pkg::OP_DIV:       begin n_s = prod_q[0]; d_s = prod_q[1]; end
      rau_pkg::OP_INC:       begin n_s = an_x + ad_x; d_s = ad_x; end
      rau_pkg::OP_DEC:       begin n_s = an_x - ad_x; d_s = ad_x; end
      rau_pkg::OP_NORMALIZE: begin n_s = an_x; d_s = ad_x; end
      rau_pkg::OP_INTVALUE:  begin n_s = an_x; d_s = ad_x; is_frac = 1'b0; end
      default:               begin n_s = '0; d_s = '0; is_frac = 1'b0; end
    endcase
    // Comparison on the cross products; a negative a_den flips the order
    diff_s = prod_q[0] - prod_q[1];
    eq_s   = (diff_s == '0);
    lt_s   = ad_q[WIDTH-1] ? (!diff_s[DW-1] && !eq_s) : diff_s[DW-1];
    gt_s   = !lt_s && !eq_s;
    case (op_q)
      rau_pkg::OP_EQ: cmp_s = eq_s;
      rau_pkg::OP_NE: cmp_s = !eq_s;
      rau_pkg::OP_LT: cmp_s = lt_s;
      rau_pkg::OP_LE: cmp_s = !gt_s;
      rau_pkg::OP_GT: cmp_s = gt_s;
      rau_pkg::OP_GE: cmp_s = !lt_s;
      default:        cmp_s = 1'b0;
    endcase
  end

  // Divider step and final range check
  always_comb begin
    rem_sh  = {rem_q, quo_q[DW-1]};
    ge_s    = (rem_sh >= {1'b0, div_q});
    rem_nx  = ge_s ? (rem_sh - {1'b0, div_q}) : rem_sh;
    quo_nx  = {quo_q[DW-2:0], ge_s};
    qd_s    = is_int ? DW'(1) : quo_q;
    neg_eff = neg_q && (qn_q != '0);
    ovf_s   = (qd_s > LIM) || (qn_q > (neg_eff ? LIM_NEG : LIM));
  end

  // Sequencer: next state and datapath loads
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    an_d      = an_q;
    ad_d      = ad_q;
    bn_d      = bn_q;
    bd_d      = bd_q;
    mul_cnt_d = mul_cnt_q;
    mn_d      = mn_q;
    md_d      = md_q;
    neg_d     = neg_q;
    u_d       = u_q;
    v_d       = v_q;
    k_d       = k_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    div_d     = div_q;
    qn_d      = qn_q;
    cnt_d     = cnt_q;
    res_num_d = res_num_q;
    res_den_d = res_den_q;
    cmp_d     = cmp_q;
    err_d     = err_q;

    case (state_q)
      rau_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_i;
          an_d      = a_num_i;
          ad_d      = a_den_i;
          bn_d      = b_num_i;
          bd_d      = b_den_i;
          mul_cnt_d = 2'd0;
          state_d   = rau_pkg::ST_MUL;
        end
      end
      rau_pkg::ST_MUL: begin
        mul_cnt_d = mul_cnt_q + 2'd1;
        if (mul_cnt_q == 2'd3) begin
          state_d = rau_pkg::ST_FORM;
        end
      end
      rau_pkg::ST_FORM: begin
        mn_d      = n_s[DW-1] ? -n_s : n_s;
        md_d      = d_s[DW-1] ? -d_s : d_s;
        neg_d     = n_s[DW-1] ^ d_s[DW-1];
        res_num_d = '0;
        res_den_d = '0;
        cmp_d     = 1'b0;
        err_d     = rau_pkg::ERR_OK;
        state_d   = rau_pkg::ST_OUT;
        if (is_cmp) begin
          if (ad_q == '0 || bd_q == '0) begin
            err_d = rau_pkg::ERR_ZERO_DEN;
          end else begin
            cmp_d = cmp_s;
          end
        end else if (is_frac || is_int) begin
          if (d_s == '0) begin
            err_d = rau_pkg::ERR_ZERO_DEN;
          end else if (is_int) begin
            // Truncating quotient |a_num| / |a_den|
            quo_d   = n_s[DW-1] ? -n_s : n_s;
            div_d   = d_s[DW-1] ? -d_s : d_s;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = rau_pkg::ST_DIV_NUM;
          end else begin
            u_d     = n_s[DW-1] ? -n_s : n_s;
            v_d     = d_s[DW-1] ? -d_s : d_s;
            k_d     = '0;
            state_d = rau_pkg::ST_GCD;
          end
        end
      end
      rau_pkg::ST_GCD: begin
        if (u_q == '0) begin
          // gcd found: divide the numerator first
          div_d   = v_q << k_q;
          quo_d   = mn_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = rau_pkg::ST_DIV_NUM;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + CW'(1);
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q >= v_q) begin
          u_d = (u_q - v_q) >> 1;
        end else begin
          v_d = (v_q - u_q) >> 1;
        end
      end
      rau_pkg::ST_DIV_NUM: begin
        rem_d = rem_nx[DW-1:0];
        quo_d = quo_nx;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          qn_d = quo_nx;
          if (is_int) begin
            state_d = rau_pkg::ST_CHECK;
          end else begin
            quo_d   = md_q;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = rau_pkg::ST_DIV_DEN;
          end
        end
      end
      rau_pkg::ST_DIV_DEN: begin
        rem_d = rem_nx[DW-1:0];
        quo_d = quo_nx;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          state_d = rau_pkg::ST_CHECK;
        end
      end
      rau_pkg::ST_CHECK: begin
        if (ovf_s) begin
          err_d     = rau_pkg::ERR_OVERFLOW;
          res_num_d = '0;
          res_den_d = '0;
        end else begin
          res_num_d = neg_eff ? -qn_q[WIDTH-1:0] : qn_q[WIDTH-1:0];
          res_den_d = qd_s[WIDTH-2:0];
        end
        state_d = rau_pkg::ST_OUT;
      end
      rau_pkg::ST_OUT: begin
        // Hold the result until the consumer takes it
        if (!out_stall_i) begin
          state_d = rau_pkg::ST_IDLE;
        end
      end
      default: state_d = rau_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rau_pkg::ST_IDLE;
      mul_cnt_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      mul_cnt_q <= mul_cnt_d;
      cnt_q     <= cnt_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    an_q      <= an_d;
    ad_q      <= ad_d;
    bn_q      <= bn_d;
    bd_q      <= bd_d;
    mn_q      <= mn_d;
    md_q      <= md_d;
    neg_q     <= neg_d;
    u_q       <= u_d;
    v_q       <= v_d;
    k_q       <= k_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    div_q     <= div_d;
    qn_q      <= qn_d;
    res_num_q <= res_num_d;
    res_den_q <= res_den_d;
    cmp_q     <= cmp_d;
    err_q     <= err_d;
    if (state_q == rau_pkg::ST_MUL) begin
      prod_q[mul_cnt_q] <= prod_s;
    end
  end

  assign in_stall_o  = (state_q != rau_pkg::ST_IDLE);
  assign out_valid_o = (state_q == rau_pkg::ST_OUT);
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign cmp_true_o  = cmp_q;
  assign error_o     = err_q;

  `RAU_ASSERT_NOW(a_busy_when_valid, clk_i, rst_ni, out_valid_o, in_stall_o, "result shown while accepting")
  `RAU_ASSERT_NEXT(a_accept_starts_mul, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == rau_pkg::ST_MUL && mul_cnt_q == 2'd0, "request not started")
  `RAU_ASSERT_NOW(a_error_zeroes, clk_i, rst_ni, out_valid_o && error_o != rau_pkg::ERR_OK, res_num_o == '0 && res_den_o == '0 && !cmp_true_o, "error result not cleared")
  `RAU_ASSERT_NOW(a_ok_den_nonzero, clk_i, rst_ni, out_valid_o && error_o == rau_pkg::ERR_OK && !cmp_true_o && res_num_o != '0, res_den_o != '0, "fraction with zero denominator")

endmodule
